/* hdl/assert_macros.svh */
// Assertion macros shared by the sprite shader RTL.
// Depends on nothing; a file that asserts includes it and has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* hdl/spzf_pkg.sv */
// Package of the sprite shader: sizes, codes and item types.
// Used by spzf_div and sprite_pixel_shader_zbuffer_fog_core; depends on nothing.
package spzf_pkg;

  // Texture geometry (powers of two) and screen limit
  localparam int TexWidth    = 64;
  localparam int TexHeight   = 64;
  localparam int NumTextures = 4;
  localparam int ScreenMax   = 4096;

  localparam int TxW        = $clog2(TexWidth);
  localparam int TyW        = $clog2(TexHeight);
  localparam int SelW       = $clog2(NumTextures);
  localparam int TexAw      = TxW + TyW;
  localparam int StoreAw    = SelW + TexAw;
  localparam int StoreWords = NumTextures * TexWidth * TexHeight;

  // Divider sizes: magnitude of the coordinate offset, then scaled by the texture size
  localparam int MagW   = 15;
  localparam int DivNW  = MagW + ((TxW > TyW - 1) ? TxW : TyW - 1);
  localparam int DivDW  = 14;
  localparam int QuotW  = (TxW > TyW) ? TxW : TyW;

  // Fog: (FogLimit - depth) / 25 as a multiply by a rounded-up reciprocal
  localparam int FogLimit = 6400;
  localparam int FogRecip = 41944;
  localparam int FogShift = 20;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenWidth   = 3'd0,
    CfgScreenHeight  = 3'd1,
    CfgSpriteWidth   = 3'd2,
    CfgSpriteHeight  = 3'd3,
    CfgSpriteCenterX = 3'd4,
    CfgSpriteDepth   = 3'd5
  } cfg_reg_e;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdShade = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         tex_select;
    logic [11:0]        texel_address;
    logic [31:0]        texel_value;
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] column_depth;
  } in_item_t;

  typedef struct packed {
    logic        write_pixel;
    logic [23:0] pixel_address;
    logic [31:0] pixel_color;
  } out_item_t;

  // Item state that rides alongside the dividers
  typedef struct packed {
    logic             cmd;
    logic [SelW-1:0]  sel;
    logic [TexAw-1:0] load_addr;
    logic [31:0]      load_value;
    logic             visible;
    logic             neg_x;
    logic             neg_y;
    logic [23:0]      pixel_address;
  } side_t;

endpackage

/* hdl/spzf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, low quotient bits kept.
// Depends on spzf_pkg; the divisor must be held steady while items are in flight (not enforced here).
module spzf_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [spzf_pkg::DivNW-1:0]    dividend_i,
  input  logic [spzf_pkg::DivDW-1:0]    divisor_i,
  output logic [spzf_pkg::QuotW-1:0]    quot_o
);

  logic [spzf_pkg::DivDW-1:0] rem_q [spzf_pkg::DivNW];
  logic [spzf_pkg::DivNW-1:0] dvd_q [spzf_pkg::DivNW];
  logic [spzf_pkg::QuotW-1:0] quo_q [spzf_pkg::DivNW];

  for (genvar k = 0; k < spzf_pkg::DivNW; k++) begin : g_stage
    logic [spzf_pkg::DivDW-1:0] rem_in;
    logic [spzf_pkg::DivNW-1:0] dvd_in;
    logic [spzf_pkg::QuotW-1:0] quo_in;
    logic [spzf_pkg::DivDW:0]   trial;
    logic [spzf_pkg::DivDW:0]   diff;
    logic                       take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor
    assign trial = {rem_in, dvd_in[spzf_pkg::DivNW-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign take  = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[spzf_pkg::DivDW-1:0] : trial[spzf_pkg::DivDW-1:0];
        dvd_q[k] <= {dvd_in[spzf_pkg::DivNW-2:0], 1'b0};
        quo_q[k] <= {quo_in[spzf_pkg::QuotW-2:0], take};
      end
    end
  end

  assign quot_o = quo_q[spzf_pkg::DivNW-1];

endmodule

/* hdl/sprite_pixel_shader_zbuffer_fog_core.sv */
// A shade item passes the entry registers, the divider stages, the sample stage and the output register.
// Throughput: one item per cycle while the output is not stalled; the 21-stage divider pipeline sets the latency.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset: asynchronous, active low; clears valid bits and loads the register defaults.
// The texture store is not cleared; it must be read only where it was written (the block does not enforce this).
// Depends on spzf_pkg, spzf_div and assert_macros.svh.
`include "assert_macros.svh"

module sprite_pixel_shader_zbuffer_fog_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  spzf_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spzf_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [spzf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [spzf_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int L = spzf_pkg::DivNW;

  logic [12:0]        scr_w_q, scr_h_q;
  logic [13:0]        spr_w_q, spr_h_q;
  logic signed [13:0] spr_cx_q;
  logic signed [15:0] spr_depth_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q     <= 13'd640;
      scr_h_q     <= 13'd480;
      spr_w_q     <= 14'd64;
      spr_h_q     <= 14'd64;
      spr_cx_q    <= 14'sd320;
      spr_depth_q <= 16'sd256;
    end else if (cfg_we_i) begin
      case (spzf_pkg::cfg_reg_e'(cfg_index_i))
        spzf_pkg::CfgScreenWidth:   scr_w_q     <= cfg_wdata_i[12:0];
        spzf_pkg::CfgScreenHeight:  scr_h_q     <= cfg_wdata_i[12:0];
        spzf_pkg::CfgSpriteWidth:   spr_w_q     <= cfg_wdata_i[13:0];
        spzf_pkg::CfgSpriteHeight:  spr_h_q     <= cfg_wdata_i[13:0];
        spzf_pkg::CfgSpriteCenterX: spr_cx_q    <= $signed(cfg_wdata_i[13:0]);
        spzf_pkg::CfgSpriteDepth:   spr_depth_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  logic [12:0] scr_w_sat, scr_h_sat;
  assign scr_w_sat = (scr_w_q > 13'(spzf_pkg::ScreenMax)) ? 13'(spzf_pkg::ScreenMax) : scr_w_q;
  assign scr_h_sat = (scr_h_q > 13'(spzf_pkg::ScreenMax)) ? 13'(spzf_pkg::ScreenMax) : scr_h_q;

  // Fog factor depends on the sprite depth only
  logic signed [16:0] fog_n;
  logic [28:0]        fog_prod;
  logic [7:0]         fog_q;
  assign fog_n    = 17'sd6400 - 17'(spr_depth_q);
  assign fog_prod = {16'b0, fog_n[12:0]} * 29'(spzf_pkg::FogRecip);

  always_ff @(posedge clk_i) begin
    if (spr_depth_q > 16'sd0 && spr_depth_q < 16'(spzf_pkg::FogLimit)) begin
      fog_q <= fog_prod[spzf_pkg::FogShift +: 8];
    end else begin
      fog_q <= 8'd0;
    end
  end

  // Global advance: the pipeline moves unless a finished item waits
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: offsets, visibility and image address
  logic signed [16:0] a_s, e_s, a_mag, e_mag;
  logic [24:0]        addr_prod;
  spzf_pkg::side_t    side_in;

  assign a_s = $signed({5'b0, in_item_i.column}) - 17'(spr_cx_q)
             + $signed({4'b0, spr_w_q[13:1]});
  assign e_s = $signed({4'b0, in_item_i.row, 1'b0}) - $signed({4'b0, scr_h_sat})
             + $signed({3'b0, spr_h_q});
  assign a_mag = a_s[16] ? -a_s : a_s;
  assign e_mag = e_s[16] ? -e_s : e_s;
  assign addr_prod = {13'b0, in_item_i.row} * {12'b0, scr_w_sat};

  always_comb begin
    side_in.cmd           = in_item_i.cmd;
    side_in.sel           = in_item_i.tex_select[spzf_pkg::SelW-1:0];
    side_in.load_addr     = in_item_i.texel_address[spzf_pkg::TexAw-1:0];
    side_in.load_value    = in_item_i.texel_value;
    side_in.visible       = (spr_depth_q > 16'sd0) && (in_item_i.column != 12'd0)
                         && ({1'b0, in_item_i.column} < scr_w_sat)
                         && (spr_depth_q < in_item_i.column_depth);
    side_in.neg_x         = a_s[16];
    side_in.neg_y         = e_s[16];
    side_in.pixel_address = addr_prod[23:0] + {12'b0, in_item_i.column};
  end

  logic                         v_q  [L+1];
  spzf_pkg::side_t              sb_q [L+1];
  logic [spzf_pkg::DivNW-1:0]   dvx_q, dvy_q;

  // Valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= L; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i <= L; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Side data line and divider operands
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= side_in;
      for (int i = 1; i <= L; i++) sb_q[i] <= sb_q[i-1];
      dvx_q <= spzf_pkg::DivNW'({a_mag[spzf_pkg::MagW-1:0], {spzf_pkg::TxW{1'b0}}});
      dvy_q <= spzf_pkg::DivNW'({e_mag[spzf_pkg::MagW-1:0], {(spzf_pkg::TyW-1){1'b0}}});
    end
  end

  logic [spzf_pkg::QuotW-1:0] qx, qy;

  spzf_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dvx_q),
    .divisor_i  (spr_w_q),
    .quot_o     (qx)
  );

  spzf_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dvy_q),
    .divisor_i  (spr_h_q),
    .quot_o     (qy)
  );

  // Texture coordinates: restore the sign, wrap by masking, zero for a zero size
  logic [spzf_pkg::QuotW-1:0]   tx_full, ty_full;
  logic [spzf_pkg::TxW-1:0]     tx;
  logic [spzf_pkg::TyW-1:0]     ty;
  logic [spzf_pkg::StoreAw-1:0] mem_addr;
  spzf_pkg::side_t              sb_l;

  assign sb_l    = sb_q[L];
  assign tx_full = sb_l.neg_x ? -qx : qx;
  assign ty_full = sb_l.neg_y ? -qy : qy;
  assign tx      = (spr_w_q == 14'd0) ? '0 : tx_full[spzf_pkg::TxW-1:0];
  assign ty      = (spr_h_q == 14'd0) ? '0 : ty_full[spzf_pkg::TyW-1:0];
  assign mem_addr = (sb_l.cmd == spzf_pkg::CmdLoad) ? {sb_l.sel, sb_l.load_addr}
                                                    : {sb_l.sel, ty, tx};

  // Texture store: loads and samples meet it at the same stage, in item order
  logic [31:0] tex_mem [spzf_pkg::StoreWords];
  logic [31:0] texel_q;

  always_ff @(posedge clk_i) begin
    if (en && v_q[L] && sb_l.cmd == spzf_pkg::CmdLoad) begin
      tex_mem[mem_addr] <= sb_l.load_value;
    end
    if (en && v_q[L] && sb_l.cmd == spzf_pkg::CmdShade) begin
      texel_q <= tex_mem[mem_addr];
    end
  end

  logic        vm_q;
  logic        vis_m_q;
  logic [23:0] paddr_m_q;

  // Sample stage: only shade items carry on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= v_q[L] && (sb_l.cmd == spzf_pkg::CmdShade);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_m_q   <= sb_l.visible;
      paddr_m_q <= sb_l.pixel_address;
    end
  end

  // Fog each channel, drop transparent or hidden pixels
  logic [15:0] r_p, g_p, b_p;
  logic [31:0] color;
  logic        keep;
  spzf_pkg::out_item_t out_d, out_q;

  assign r_p   = texel_q[23:16] * fog_q;
  assign g_p   = texel_q[15:8] * fog_q;
  assign b_p   = texel_q[7:0] * fog_q;
  assign color = {texel_q[31:24], r_p[15:8], g_p[15:8], b_p[15:8]};
  assign keep  = vis_m_q && (color[23:0] != 24'd0);

  always_comb begin
    out_d.write_pixel   = keep;
    out_d.pixel_address = keep ? paddr_m_q : 24'd0;
    out_d.pixel_color   = keep ? color : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `ASSERT_IMPLY(a_reject_zero, out_valid_o && !out_item_o.write_pixel,
    out_item_o.pixel_address == 24'd0 && out_item_o.pixel_color == 32'd0,
    "rejected pixel carries data")
  `ASSERT_IMPLY(a_write_opaque, out_valid_o && out_item_o.write_pixel,
    out_item_o.pixel_color[23:0] != 24'd0, "transparent pixel written")
  `ASSERT_IMPLY(a_stall_blocks, out_valid_o && !out_ready_i, !in_ready_o,
    "item taken while output stalled")

endmodule
